>>> rtl/core/ddo_pkg.sv
// ----------------------------------------------------------------------------
// Differential drive odometry package
// Shared constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int unsigned CordicSteps = 30;
  localparam int unsigned CordicIterW = 5;
  localparam int unsigned CordicW     = 34;
  localparam logic [31:0] CordicGain  = 32'd652032874;

  localparam int unsigned MulAW = 64;
  localparam int unsigned MulBW = 33;
  localparam int unsigned MulPW = MulAW + MulBW;

  localparam int unsigned DivNW = 66;
  localparam int unsigned DivDW = 32;
  localparam int unsigned DivCntW = 7;

  localparam logic [MulBW-1:0] MsPerSec = 33'd1000;

  function automatic logic [29:0] atan_turn(input logic [CordicIterW-1:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/ddo_mul.sv
// ----------------------------------------------------------------------------
// Shift-add multiplier
// Unsigned multiply, one multiplier bit per cycle, stops when bits run out.
// ----------------------------------------------------------------------------
module ddo_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ddo_pkg::MulAW-1:0]   a_i,
  input  logic [ddo_pkg::MulBW-1:0]   b_i,
  output logic                        done_o,
  output logic [ddo_pkg::MulPW-1:0]   prod_o
);

  logic                      busy_q;
  logic [ddo_pkg::MulPW-1:0] a_q;
  logic [ddo_pkg::MulBW-1:0] b_q;
  logic [ddo_pkg::MulPW-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && (b_q == '0)) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= {{ddo_pkg::MulBW{1'b0}}, a_i};
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q && (b_q != '0)) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign done_o = busy_q && (b_q == '0);
  assign prod_o = acc_q;

endmodule

>>> rtl/core/ddo_div.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ddo_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ddo_pkg::DivNW-1:0]   num_i,
  input  logic [ddo_pkg::DivDW-1:0]   den_i,
  output logic                        done_o,
  output logic [ddo_pkg::DivNW-1:0]   quo_o
);

  logic                        busy_q;
  logic [ddo_pkg::DivCntW-1:0] cnt_q;
  logic [ddo_pkg::DivDW-1:0]   rem_q;
  logic [ddo_pkg::DivDW-1:0]   den_q;
  logic [ddo_pkg::DivNW-1:0]   quo_q;
  logic [ddo_pkg::DivDW:0]     trial;
  logic                        fits;

  assign trial = {rem_q, quo_q[ddo_pkg::DivNW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= ddo_pkg::DivCntW'(ddo_pkg::DivNW);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= num_i;
    end else if (busy_q && (cnt_q != '0)) begin
      rem_q <= fits ? ddo_pkg::DivDW'(trial - {1'b0, den_q}) : trial[ddo_pkg::DivDW-1:0];
      quo_q <= {quo_q[ddo_pkg::DivNW-2:0], fits};
    end
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign quo_o  = quo_q;

endmodule

>>> rtl/core/ddo_cordic.sv
// ----------------------------------------------------------------------------
// Iterative CORDIC
// Sine and cosine of a binary angle (2^32 per turn) as Q2.30 magnitudes with signs, one rotation per cycle.
// ----------------------------------------------------------------------------
module ddo_cordic (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] ang_i,
  output logic        done_o,
  output logic [31:0] cos_mag_o,
  output logic        cos_neg_o,
  output logic [31:0] sin_mag_o,
  output logic        sin_neg_o
);

  localparam int unsigned W = ddo_pkg::CordicW;

  logic                            busy_q;
  logic [ddo_pkg::CordicIterW-1:0] idx_q;
  logic signed [W-1:0]             x_q, y_q, z_q;
  logic                            flip_q;
  logic [31:0]                     ang_rot;
  logic                            flip;
  logic signed [W-1:0]             xs, ys, at;
  logic [W-1:0]                    x_abs, y_abs;

  assign flip    = ang_i[31] ^ ang_i[30];
  assign ang_rot = flip ? (ang_i + 32'h8000_0000) : ang_i;
  assign xs      = x_q >>> idx_q;
  assign ys      = y_q >>> idx_q;
  assign at      = signed'({4'b0, ddo_pkg::atan_turn(idx_q)});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (busy_q) begin
      if (idx_q == ddo_pkg::CordicIterW'(ddo_pkg::CordicSteps)) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= signed'({2'b0, ddo_pkg::CordicGain});
      y_q    <= '0;
      z_q    <= signed'({{(W-32){ang_rot[31]}}, ang_rot});
      flip_q <= flip;
    end else if (busy_q && (idx_q != ddo_pkg::CordicIterW'(ddo_pkg::CordicSteps))) begin
      if (!z_q[W-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  assign x_abs     = x_q[W-1] ? W'(-x_q) : W'(x_q);
  assign y_abs     = y_q[W-1] ? W'(-y_q) : W'(y_q);
  assign done_o    = busy_q && (idx_q == ddo_pkg::CordicIterW'(ddo_pkg::CordicSteps));
  assign cos_mag_o = x_abs[31:0];
  assign sin_mag_o = y_abs[31:0];
  assign cos_neg_o = x_q[W-1] ^ flip_q;
  assign sin_neg_o = y_q[W-1] ^ flip_q;

endmodule

>>> rtl/core/diff_drive_odometry.sv
// ----------------------------------------------------------------------------
// Differential drive odometry
// Integrates a planar pose from four wheel encoder counts.
// ----------------------------------------------------------------------------
// A start item, or an update whose time has not moved, passes from acceptance
// through preparation, which raises its result. A full update uses these units:
// - One shared shift-add multiplier runs six products. The multiplier operand
//   has up to 33 significant bits for the travel, 32 for the turn, 31 each for
//   the cosine and sine projections, and 10 for each scaling by 1000.
// - The CORDIC gives the cosine and sine of the midpoint heading.
// - The restoring divider runs one division for each of the two velocities.
// One item is in work at a time, and the next is taken once the result has been
// delivered.
module diff_drive_odometry #(
  parameter int unsigned POSE_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [31:0] front_left_count_i,
  input  logic [31:0] rear_left_count_i,
  input  logic [31:0] front_right_count_i,
  input  logic [31:0] rear_right_count_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] pos_x_o,
  output logic [31:0] pos_y_o,
  output logic [31:0] heading_o,
  output logic [31:0] lin_vel_o,
  output logic [31:0] ang_vel_o,
  output logic        updated_o
);

  localparam int unsigned DlShift = 33 - POSE_FRAC_BITS;
  localparam logic        CfgMetersPerTick = 1'b0;
  localparam logic        CfgAnglePerTick  = 1'b1;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_PREP   = 11'b000_0000_0010,
    S_MUL_DL = 11'b000_0000_0100,
    S_MUL_TH = 11'b000_0000_1000,
    S_CORDIC = 11'b000_0001_0000,
    S_MUL_X  = 11'b000_0010_0000,
    S_MUL_Y  = 11'b000_0100_0000,
    S_MUL_V  = 11'b000_1000_0000,
    S_DIV_V  = 11'b001_0000_0000,
    S_MUL_W  = 11'b010_0000_0000,
    S_DIV_W  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   kick_q;
  logic   out_valid_q;
  logic   updated_q;

  logic [31:0] mpt_q, apt_q;
  logic [31:0] last_left_q, last_right_q, last_time_q;
  logic [31:0] x_q, y_q, theta_q, vel_q, omega_q;

  logic        cmd_q;
  logic [31:0] left_q, right_q, now_q;
  logic        sum_neg_q, diff_neg_q;
  logic [32:0] sum_mag_q, diff_mag_q;
  logic [31:0] dt_q;
  logic [63:0] dl_m_q, th_m_q;

  logic        in_fire, out_fire;
  logic [32:0] fl_sum, fr_sum;
  logic [32:0] left_avg, right_avg;
  logic [31:0] dl, dr, dt;
  logic [32:0] dsum, ddiff;
  logic [31:0] h32, th32;

  logic                         mul_start, mul_done;
  logic [ddo_pkg::MulAW-1:0]    mul_a;
  logic [ddo_pkg::MulBW-1:0]    mul_b;
  logic [ddo_pkg::MulPW-1:0]    mul_p;
  logic                         div_start, div_done;
  logic [ddo_pkg::DivNW-1:0]    div_q;
  logic                         cor_start, cor_done;
  logic [31:0]                  cos_mag, sin_mag;
  logic                         cos_neg, sin_neg;
  logic [55:0]                  term;

  function automatic logic [31:0] sat_acc(input logic [31:0] acc, input logic neg,
                                          input logic [55:0] t);
    logic signed [57:0] a;
    logic signed [57:0] b;
    logic signed [57:0] s;
    logic [31:0]        r;
    a = signed'({{26{acc[31]}}, acc});
    b = signed'({2'b0, t});
    s = neg ? (a - b) : (a + b);
    if (s > 58'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (s < -58'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] sat_rate(input logic [65:0] q, input logic neg);
    logic        big;
    logic [31:0] r;
    big = |q[65:31];
    if (neg) begin
      r = big ? 32'h8000_0000 : (32'd0 - q[31:0]);
    end else begin
      r = big ? 32'h7FFF_FFFF : q[31:0];
    end
    return r;
  endfunction

  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && !out_valid_q;

  assign fl_sum    = {front_left_count_i[31], front_left_count_i}
                   + {rear_left_count_i[31], rear_left_count_i};
  assign fr_sum    = {front_right_count_i[31], front_right_count_i}
                   + {rear_right_count_i[31], rear_right_count_i};
  assign left_avg  = 33'($signed(fl_sum + {32'd0, fl_sum[32]}) >>> 1);
  assign right_avg = 33'($signed(fr_sum + {32'd0, fr_sum[32]}) >>> 1);

  assign dl    = left_q - last_left_q;
  assign dr    = right_q - last_right_q;
  assign dt    = now_q - last_time_q;
  assign dsum  = {dl[31], dl} + {dr[31], dr};
  assign ddiff = {dr[31], dr} - {dl[31], dl};

  assign h32  = diff_neg_q ? (32'd0 - th_m_q[32:1]) : th_m_q[32:1];
  assign th32 = diff_neg_q ? (32'd0 - th_m_q[31:0]) : th_m_q[31:0];
  assign term = mul_p[85:30];

  always_comb begin
    unique case (state_q)
      S_MUL_DL: begin
        mul_a = {32'd0, mpt_q};
        mul_b = sum_mag_q;
      end
      S_MUL_TH: begin
        mul_a = {32'd0, apt_q};
        mul_b = diff_mag_q;
      end
      S_MUL_X: begin
        mul_a = dl_m_q;
        mul_b = {1'b0, cos_mag};
      end
      S_MUL_Y: begin
        mul_a = dl_m_q;
        mul_b = {1'b0, sin_mag};
      end
      S_MUL_W: begin
        mul_a = {16'd0, th_m_q[63:16]};
        mul_b = ddo_pkg::MsPerSec;
      end
      default: begin
        mul_a = dl_m_q;
        mul_b = ddo_pkg::MsPerSec;
      end
    endcase
  end

  assign mul_start = kick_q && ((state_q == S_MUL_DL) || (state_q == S_MUL_TH) ||
                                (state_q == S_MUL_X) || (state_q == S_MUL_Y) ||
                                (state_q == S_MUL_V) || (state_q == S_MUL_W));
  assign div_start = kick_q && ((state_q == S_DIV_V) || (state_q == S_DIV_W));
  assign cor_start = kick_q && (state_q == S_CORDIC);

  ddo_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  ddo_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mul_p[ddo_pkg::DivNW-1:0]),
    .den_i   (dt_q),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  ddo_cordic u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cor_start),
    .ang_i     (theta_q + h32),
    .done_o    (cor_done),
    .cos_mag_o (cos_mag),
    .cos_neg_o (cos_neg),
    .sin_mag_o (sin_mag),
    .sin_neg_o (sin_neg)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_fire) state_d = S_PREP;
      S_PREP: begin
        if (cmd_q && (dt != '0)) begin
          state_d = S_MUL_DL;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_MUL_DL: if (mul_done && !kick_q) state_d = S_MUL_TH;
      S_MUL_TH: if (mul_done && !kick_q) state_d = S_CORDIC;
      S_CORDIC: if (cor_done) state_d = S_MUL_X;
      S_MUL_X:  if (mul_done && !kick_q) state_d = S_MUL_Y;
      S_MUL_Y:  if (mul_done && !kick_q) state_d = S_MUL_V;
      S_MUL_V:  if (mul_done && !kick_q) state_d = S_DIV_V;
      S_DIV_V:  if (div_done) state_d = S_MUL_W;
      S_MUL_W:  if (mul_done && !kick_q) state_d = S_DIV_W;
      S_DIV_W:  if (div_done) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      kick_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      updated_q    <= 1'b0;
      mpt_q        <= 32'd809585;
      apt_q        <= 32'd644000;
      last_left_q  <= '0;
      last_right_q <= '0;
      last_time_q  <= '0;
      x_q          <= '0;
      y_q          <= '0;
      theta_q      <= '0;
      vel_q        <= '0;
      omega_q      <= '0;
    end else begin
      state_q <= state_d;
      kick_q  <= (state_d != state_q);
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgMetersPerTick: mpt_q <= cfg_data_i;
          CfgAnglePerTick:  apt_q <= cfg_data_i;
          default:          mpt_q <= mpt_q;
        endcase
      end
      if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_PREP) begin
        if (!cmd_q) begin
          last_left_q  <= left_q;
          last_right_q <= right_q;
          last_time_q  <= now_q;
        end
        if (!cmd_q || (dt == '0)) begin
          updated_q   <= 1'b0;
          out_valid_q <= 1'b1;
        end
      end
      if ((state_q == S_MUL_X) && mul_done && !kick_q) begin
        x_q <= sat_acc(x_q, sum_neg_q ^ cos_neg, term);
      end
      if ((state_q == S_MUL_Y) && mul_done && !kick_q) begin
        y_q <= sat_acc(y_q, sum_neg_q ^ sin_neg, term);
      end
      if ((state_q == S_DIV_V) && div_done) begin
        vel_q <= sat_rate(div_q, sum_neg_q);
      end
      if ((state_q == S_DIV_W) && div_done) begin
        omega_q      <= sat_rate(div_q, diff_neg_q);
        theta_q      <= theta_q + th32;
        last_left_q  <= left_q;
        last_right_q <= right_q;
        last_time_q  <= now_q;
        updated_q    <= 1'b1;
        out_valid_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= cmd_i;
      left_q  <= left_avg[31:0];
      right_q <= right_avg[31:0];
      now_q   <= now_ms_i;
    end
    if (state_q == S_PREP) begin
      sum_neg_q  <= dsum[32];
      sum_mag_q  <= dsum[32] ? (33'd0 - dsum) : dsum;
      diff_neg_q <= ddiff[32];
      diff_mag_q <= ddiff[32] ? (33'd0 - ddiff) : ddiff;
      dt_q       <= dt;
    end
    if ((state_q == S_MUL_DL) && mul_done && !kick_q) begin
      dl_m_q <= 64'(mul_p >> DlShift);
    end
    if ((state_q == S_MUL_TH) && mul_done && !kick_q) begin
      th_m_q <= mul_p[63:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = x_q;
  assign pos_y_o     = y_q;
  assign heading_o   = theta_q;
  assign lin_vel_o   = vel_q;
  assign ang_vel_o   = omega_q;
  assign updated_o   = updated_q;

  a_out_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == S_IDLE))
    else $error("Result is pending while an item is still in work.");

  a_accept_to_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> ((state_q == S_PREP) && !out_valid_q))
    else $error("Accepted item did not enter preparation.");

  a_prep_branch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PREP) |=> ((state_q == S_IDLE) || (state_q == S_MUL_DL)))
    else $error("Preparation left to an unexpected step.");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q == S_PREP) || $past(state_q == S_DIV_W)))
    else $error("Result raised outside preparation or final division.");

endmodule

>>> verif/diff_drive_odometry_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Differential drive odometry testbench
// Drives start and update items through the valid/ready input under bursty
// traffic, predicts every pose result with an independent fixed-point model
// of the midpoint integration, and checks each delivered result field by
// field while the output side stalls on its own pattern.
// ----------------------------------------------------------------------------
module diff_drive_odometry_test;

  localparam int unsigned PoseFrac  = 16;
  localparam int unsigned IdleLimit = 6000;
  localparam logic        CmdStart  = 1'b0;
  localparam logic        CmdUpdate = 1'b1;
  localparam logic        IdxMetersPerTick = 1'b0;
  localparam logic        IdxAnglePerTick  = 1'b1;
  localparam longint      CosGain = 64'd652032874;

  typedef struct packed {
    logic        cmd;
    logic [31:0] fl, rl, fr, rr, now;
  } odo_item_t;

  typedef struct packed {
    logic [31:0] x, y, hd, lv, av;
    logic        upd;
  } pose_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        cmd_i = 1'b0;
  logic [31:0] front_left_count_i = '0;
  logic [31:0] rear_left_count_i = '0;
  logic [31:0] front_right_count_i = '0;
  logic [31:0] rear_right_count_i = '0;
  logic [31:0] now_ms_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] pos_x_o, pos_y_o, heading_o, lin_vel_o, ang_vel_o;
  logic        updated_o;

  diff_drive_odometry #(.POSE_FRAC_BITS(PoseFrac)) dut (.*);

  always #6 clk_i = ~clk_i;

  odo_item_t pending_items[$];
  pose_t     expected_poses[$];
  bit        failed = 1'b0;

  // Predictor state.
  bit [31:0] m_per_tick, a_per_tick;
  bit [31:0] prev_left, prev_right, prev_time;
  bit [31:0] px, py, ptheta, pvel, pomega;

  longint atan_tab [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
    5, 3, 1};

  function automatic longint sx32(bit [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic bit [63:0] mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic bit [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic bit [31:0] side_mean(bit [31:0] a, bit [31:0] b);
    longint s;
    s = sx32(a) + sx32(b);
    s = s / 2;
    return s[31:0];
  endfunction

  function automatic void sin_cos(input bit [31:0] ang, output longint c,
                                  output longint s);
    bit [31:0] probe;
    bit        flip;
    longint    x, y, z, nx;
    probe = ang + 32'h4000_0000;
    flip = probe[31];
    if (flip) ang = ang + 32'h8000_0000;
    z = sx32(ang);
    x = CosGain;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_tab[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint project(bit [63:0] m, bit neg, longint k);
    bit [63:0] km, hi, lo, t;
    km = mag(k);
    hi = m >> 32;
    lo = {32'd0, m[31:0]};
    t = ((hi * km) << 2) + ((lo * km) >> 30);
    return (neg != (k < 0)) ? -longint'(t) : longint'(t);
  endfunction

  function automatic bit [31:0] per_second(bit [63:0] m, bit neg, bit [31:0] dt);
    bit [63:0] q, r, res;
    q = m / dt;
    r = m % dt;
    if (q >= 64'h1_0000_0000) res = 64'd4294967296000;
    else res = q * 1000 + (r * 1000) / dt;
    if (neg) return res >= 64'h8000_0000 ? 32'h8000_0000 : 32'(-res);
    return res > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : res[31:0];
  endfunction

  function automatic pose_t advance_pose(odo_item_t it);
    bit [31:0] left, right, dt, th32, h32, dtmp;
    longint    dl, dr, dsum, ddiff, c, s;
    bit [63:0] trav, turn, half;
    bit        trav_neg, turn_neg;
    pose_t     r;
    left = side_mean(it.fl, it.rl);
    right = side_mean(it.fr, it.rr);
    dt = it.now - prev_time;
    r.upd = 1'b0;
    if (it.cmd == CmdStart) begin
      prev_left = left;
      prev_right = right;
      prev_time = it.now;
    end else if (dt != 0) begin
      dtmp = left - prev_left;
      dl = sx32(dtmp);
      dtmp = right - prev_right;
      dr = sx32(dtmp);
      dsum = dl + dr;
      ddiff = dr - dl;
      trav = (mag(dsum) * {32'd0, m_per_tick}) >> (33 - PoseFrac);
      trav_neg = dsum < 0;
      turn = mag(ddiff) * {32'd0, a_per_tick};
      turn_neg = ddiff < 0;
      th32 = turn_neg ? 32'(-turn) : turn[31:0];
      half = turn >> 1;
      h32 = turn_neg ? 32'(-half) : half[31:0];
      sin_cos(ptheta + h32, c, s);
      px = sat32(sx32(px) + project(trav, trav_neg, c));
      py = sat32(sx32(py) + project(trav, trav_neg, s));
      ptheta = ptheta + th32;
      pvel = per_second(trav, trav_neg, dt);
      pomega = per_second(turn >> 16, turn_neg, dt);
      prev_left = left;
      prev_right = right;
      prev_time = it.now;
      r.upd = 1'b1;
    end
    r.x = px;
    r.y = py;
    r.hd = ptheta;
    r.lv = pvel;
    r.av = pomega;
    return r;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int unsigned burst_left = 0, gap_left = 0;
  int unsigned idle_cycles = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_poses.push_back(advance_pose(pending_items.pop_front()));
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cmd_i <= pending_items[0].cmd;
          front_left_count_i <= pending_items[0].fl;
          rear_left_count_i <= pending_items[0].rl;
          front_right_count_i <= pending_items[0].fr;
          rear_right_count_i <= pending_items[0].rr;
          now_ms_i <= pending_items[0].now;
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: changing stall modes, plus one long hold-off.
  int unsigned results_seen = 0, hold_left = 0, mode = 0, mode_left = 0;
  bit          long_hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) results_seen++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (results_seen == 300 && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_left = 800;
        out_ready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(16, 128);
        end else begin
          mode_left--;
        end
        case (mode)
          0: begin
            out_ready_i <= 1'b1;
          end
          1: begin
            out_ready_i <= 1'($urandom_range(0, 1));
          end
          default: begin
            out_ready_i <= ($urandom_range(0, 7) == 0);
          end
        endcase
      end
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      failed = 1'b1;
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_poses.size() == 0) begin
        failed = 1'b1;
        $display("%0t: unexpected result, expected none, actual x=%h y=%h", $realtime,
                 pos_x_o, pos_y_o);
      end else begin
        pose_t e;
        e = expected_poses.pop_front();
        check_field("pos_x", e.x, pos_x_o);
        check_field("pos_y", e.y, pos_y_o);
        check_field("heading", e.hd, heading_o);
        check_field("lin_vel", e.lv, lin_vel_o);
        check_field("ang_vel", e.av, ang_vel_o);
        check_field("updated", 32'(e.upd), 32'(updated_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("diff_drive_odometry test failed");
      $finish;
    end
  end

  // Stimulus generation.
  bit [31:0] wheel [4];
  bit [31:0] clock_ms;

  task automatic push_item(logic cmd, logic [31:0] fl, logic [31:0] rl,
                           logic [31:0] fr, logic [31:0] rr, logic [31:0] now);
    odo_item_t it;
    it = '{cmd: cmd, fl: fl, rl: rl, fr: fr, rr: rr, now: now};
    pending_items.push_back(it);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    if (idx == IdxMetersPerTick) m_per_tick = value;
    else a_per_tick = value;
  endtask

  task automatic set_config(logic [31:0] mpt, logic [31:0] apt);
    wait (pending_items.size() == 0 && expected_poses.size() == 0);
    repeat (10) @(posedge clk_i);
    write_reg(IdxMetersPerTick, mpt);
    write_reg(IdxAnglePerTick, apt);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_items(int unsigned n);
    int unsigned r;
    int          d_left, d_right;
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        push_item(1'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          d_left = $urandom;
          d_right = $urandom;
        end else begin
          d_left = int'($urandom_range(0, 4000)) - 2000;
          d_right = d_left + int'($urandom_range(0, 400)) - 200;
        end
        wheel[0] += d_left + int'($urandom_range(0, 6)) - 3;
        wheel[1] += d_left + int'($urandom_range(0, 6)) - 3;
        wheel[2] += d_right + int'($urandom_range(0, 6)) - 3;
        wheel[3] += d_right + int'($urandom_range(0, 6)) - 3;
        if ($urandom_range(0, 9) != 0) begin
          clock_ms += ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(1, 50);
        end
        push_item(r < 16 ? CmdStart : CmdUpdate, wheel[0], wheel[1], wheel[2],
                  wheel[3], clock_ms);
      end
    end
  endtask

  initial begin
    m_per_tick = 32'd809585;
    a_per_tick = 32'd644000;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_config(32'd809585, 32'd644000);
    push_item(CmdUpdate, 32'd100, 32'd102, 32'd300, 32'd298, 32'd5);
    push_item(CmdStart, 32'd0, 32'd0, 32'd0, 32'd0, 32'd10);
    push_item(CmdUpdate, 32'd50, 32'd50, 32'd50, 32'd50, 32'd10);
    push_item(CmdUpdate, 32'd1000, 32'd1000, 32'd1200, 32'd1200, 32'd20);
    push_item(CmdStart, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'hFFFF_FFFF);
    push_item(CmdUpdate, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'd0);
    push_item(CmdUpdate, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
              32'd1);
    push_item(CmdUpdate, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFD, 32'd0, 32'd2);
    push_item(CmdUpdate, 32'hFFFF_FFFD, 32'd0, 32'd3, 32'd0, 32'd3);
    for (int i = 1; i <= 8; i++) begin
      push_item(CmdUpdate, 32'(i) << 30, 32'(i) << 30, 32'(i) << 29, 32'(i) << 29,
                32'(3 + i));
    end
    push_item(CmdUpdate, 32'd5, 32'd5, 32'hFFFF_FF00, 32'hFFFF_FF00, 32'hFFFF_FFF0);
    push_item(CmdStart, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    random_items(230);

    set_config(32'd0, 32'd0);
    random_items(240);
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_items(240);
    set_config($urandom, $urandom);
    random_items(240);
    set_config($urandom_range(0, 32'h000F_FFFF), $urandom_range(0, 32'h00FF_FFFF));
    random_items(240);

    wait (pending_items.size() == 0 && expected_poses.size() == 0);
    repeat (400) @(posedge clk_i);
    if (!failed && expected_poses.size() == 0) begin
      $display("diff_drive_odometry test passed");
    end else begin
      $display("diff_drive_odometry test failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/ddo_pkg.sv
rtl/core/ddo_mul.sv
rtl/core/ddo_div.sv
rtl/core/ddo_cordic.sv
rtl/core/diff_drive_odometry.sv
verif/diff_drive_odometry_test.sv
